>>> rtl/bad_pkg.sv
// Shared types and constants of the box-average image downscaler.
package bad_pkg;

    // Clamp limits of the configuration registers.
    localparam logic [4:0]  MAX_FACTOR = 5'd16;
    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // Line store depth in block columns.
    localparam int LINE_DEPTH = 4096;

    // Configuration register indexes.
    localparam logic [1:0] REG_FACTOR = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_COLOR  = 2'd3;

    // Order of the divisions run after reset or a register write.
    localparam logic [1:0] SETUP_BLOCKS_W = 2'd0;
    localparam logic [1:0] SETUP_BLOCKS_H = 2'd1;
    localparam logic [1:0] SETUP_COLUMN   = 2'd2;
    localparam logic [1:0] SETUP_ROW      = 2'd3;

    // Serial divider sizes.
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 9;

    // Sequencer that derives block counts and block positions.
    typedef enum logic [1:0] {
        SU_START,
        SU_WAIT,
        SU_READY
    } setup_state_t;

    // Per-pixel sequencer of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // What one accepted pixel does to the lanes.
    typedef struct packed {
        logic        active;
        logic        first_col;
        logic        seg_end;
        logic        first_row;
        logic        last_row;
        logic        last_blk;
        logic [11:0] bx;
    } step_t;

endpackage

>>> rtl/bad_div.sv
// Restoring serial divider, one quotient bit per cycle.
module bad_div
    import bad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder,
    output logic                  done
);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [4:0]            cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Control: iteration count, busy and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd1) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> rtl/bad_lane.sv
// One colour channel: row segment sum, line store slice and block average.
module bad_lane
    import bad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] pix,
    input  step_t      step,
    input  step_t      op,
    input  logic       rd_en,
    input  logic       upd,
    input  logic [8:0] area,
    output logic [7:0] avg,
    output logic       done
);

    logic [11:0] hsum_reg;
    logic [15:0] rdata_reg;
    logic [15:0] sum_next;
    logic [15:0] line_mem [LINE_DEPTH];
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
    logic                  div_start;
    logic                  rem_seen;

    // Segment sum of the current block row, restarted on the block's first column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsum_reg <= '0;
        end
        else if (accept && step.active)
        begin
            hsum_reg <= step.first_col ? {4'd0, pix} : hsum_reg + {4'd0, pix};
        end
    end

    // Column sum of the block so far.
    assign sum_next = op.first_row ? {4'd0, hsum_reg} : rdata_reg + {4'd0, hsum_reg};

    // Line store: read, then written back in the cycle after the read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= line_mem[op.bx];
        end
        if (upd)
        begin
            line_mem[op.bx] <= sum_next;
        end
    end

    // Rounded average of the finished block.
    assign div_start = upd && op.last_row;

    bad_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  ({1'b0, sum_next} + {8'd0, area[8:1]}),
        .divisor   (area),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (done)
    );

    // The remainder is not needed here; the quotient never exceeds 255.
    assign rem_seen = |remainder;
    assign avg      = quotient[7:0] | {7'd0, rem_seen & 1'b0};

endmodule

>>> rtl/bad_ctrl.sv
// Configuration registers, pixel position counters and block geometry.
module bad_ctrl
    import bad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        accept,
    input  logic        frame_start,
    output step_t       step,
    output logic        busy,
    output logic        color_mode,
    output logic [8:0]  area
);

    logic [4:0]  factor_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic        color_reg;
    logic [4:0]  f_c;
    logic [12:0] w_c;
    logic [12:0] h_c;

    logic [12:0] col_reg, col_next;
    logic [12:0] row_reg, row_next;
    logic [4:0]  dx_reg, dx_next;
    logic [4:0]  dy_reg, dy_next;
    logic [12:0] bx_reg, bx_next;
    logic [12:0] by_reg, by_next;
    logic [12:0] blocks_w_reg;
    logic [12:0] blocks_h_reg;

    setup_state_t su_reg, su_next;
    logic [1:0]   idx_reg;
    logic         div_start;
    logic [12:0]  div_num;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
    logic                  div_done;

    // Clamped register values.
    always_comb
    begin
        f_c = (factor_reg == 5'd0) ? 5'd1 : ((factor_reg > MAX_FACTOR) ? MAX_FACTOR : factor_reg);
        w_c = (width_reg == 13'd0) ? 13'd1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h_c = (height_reg == 13'd0) ? 13'd1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    end

    assign area       = {4'd0, f_c} * {4'd0, f_c};
    assign color_mode = color_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= 5'd2;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            color_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FACTOR: factor_reg <= cfg_data[4:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_COLOR:  color_reg  <= cfg_data[0];
                default:    factor_reg <= factor_reg;
            endcase
        end
    end

    // Position update for one pixel: frame start, late row wrap, then advance.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        bx_next  = bx_reg;
        by_next  = by_reg;
        step     = '0;
        if (frame_start)
        begin
            col_next = '0;
            row_next = '0;
            dx_next  = '0;
            dy_next  = '0;
            bx_next  = '0;
            by_next  = '0;
        end
        if (col_next >= w_c)
        begin
            col_next = '0;
            dx_next  = '0;
            bx_next  = '0;
            if (row_next < h_c)
            begin
                row_next = row_next + 13'd1;
                if (dy_next + 5'd1 == f_c)
                begin
                    dy_next = '0;
                    by_next = by_next + 13'd1;
                end
                else
                begin
                    dy_next = dy_next + 5'd1;
                end
            end
        end
        if (row_next < h_c)
        begin
            step.active    = (bx_next < blocks_w_reg) && (by_next < blocks_h_reg);
            step.first_col = dx_next == 5'd0;
            step.seg_end   = dx_next + 5'd1 == f_c;
            step.first_row = dy_next == 5'd0;
            step.last_row  = dy_next + 5'd1 == f_c;
            step.last_blk  = (bx_next == blocks_w_reg - 13'd1) &&
                             (by_next == blocks_h_reg - 13'd1);
            step.bx        = bx_next[11:0];
            col_next = col_next + 13'd1;
            if (dx_next + 5'd1 == f_c)
            begin
                dx_next = '0;
                bx_next = bx_next + 13'd1;
            end
            else
            begin
                dx_next = dx_next + 5'd1;
            end
            if (col_next >= w_c)
            begin
                col_next = '0;
                dx_next  = '0;
                bx_next  = '0;
                row_next = row_next + 13'd1;
                if (dy_next + 5'd1 == f_c)
                begin
                    dy_next = '0;
                    by_next = by_next + 13'd1;
                end
                else
                begin
                    dy_next = dy_next + 5'd1;
                end
            end
        end
    end

    // Setup sequencer: next state.
    always_comb
    begin
        su_next = su_reg;
        case (su_reg)
            SU_START: su_next = SU_WAIT;
            SU_WAIT:
            begin
                if (div_done && (idx_reg == SETUP_ROW))
                begin
                    su_next = SU_READY;
                end
                else if (div_done)
                begin
                    su_next = SU_START;
                end
            end
            SU_READY: su_next = SU_READY;
            default:  su_next = SU_START;
        endcase
        if (cfg_we)
        begin
            su_next = SU_START;
        end
    end

    // Setup sequencer: outputs.
    always_comb
    begin
        div_start = 1'b0;
        busy      = 1'b1;
        case (su_reg)
            SU_START: div_start = 1'b1;
            SU_WAIT:  div_start = 1'b0;
            SU_READY: busy      = 1'b0;
            default:  busy      = 1'b1;
        endcase
    end

    // Dividend for each setup division.
    always_comb
    begin
        case (idx_reg)
            SETUP_BLOCKS_W: div_num = w_c;
            SETUP_BLOCKS_H: div_num = h_c;
            SETUP_COLUMN:   div_num = col_reg;
            SETUP_ROW:      div_num = row_reg;
            default:        div_num = w_c;
        endcase
    end

    bad_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  ({4'd0, div_num}),
        .divisor   ({4'd0, f_c}),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    // Sequencer state, geometry and positions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_reg       <= SU_START;
            idx_reg      <= SETUP_BLOCKS_W;
            blocks_w_reg <= '0;
            blocks_h_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
        end
        else
        begin
            su_reg <= su_next;
            if (cfg_we)
            begin
                idx_reg <= SETUP_BLOCKS_W;
            end
            else if ((su_reg == SU_WAIT) && div_done)
            begin
                idx_reg <= idx_reg + 2'd1;
                case (idx_reg)
                    SETUP_BLOCKS_W: blocks_w_reg <= quotient[12:0];
                    SETUP_BLOCKS_H: blocks_h_reg <= quotient[12:0];
                    SETUP_COLUMN:
                    begin
                        bx_reg <= quotient[12:0];
                        dx_reg <= remainder[4:0];
                    end
                    SETUP_ROW:
                    begin
                        by_reg <= quotient[12:0];
                        dy_reg <= remainder[4:0];
                    end
                    default: blocks_w_reg <= blocks_w_reg;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                dx_reg  <= dx_next;
                dy_reg  <= dy_next;
                bx_reg  <= bx_next;
                by_reg  <= by_next;
            end
        end
    end

endmodule

>>> rtl/box_average_image_downscaler_core.sv
// Top level of the box-average image downscaler: sequencer, lanes and output register.
//
// Pixels arrive in raster order on the s_axis channel, one per beat; tuser
// flags the first pixel of a frame. Each factor-by-factor block gives one
// averaged pixel on the m_axis channel, with tlast on the frame's last one.
// Three channel lanes run side by side; grey mode feeds zeros to green and blue.
// Registers are written through cfg_we, cfg_index and cfg_data.
// A beat that does not end a block row segment is taken without the sequencer
// leaving idle. One that ends a segment holds s_axis_tready low through the
// line store read and write back; one that completes a block also through the
// 17-step serial divide in each lane and the emit into the output register,
// which raises m_axis_tvalid.
// After reset and after every register write, s_axis_tready stays low while
// one shared divider derives block counts and block positions. Reset clears
// positions and restores register defaults; the line store is not cleared. A
// result waiting in the output register does not stop the next beat from being
// taken; only the following completed block waits while m_axis_tready is low.
module box_average_image_downscaler_core
    import bad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red_or_grey, in_green, in_blue
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red_or_grey, out_green, out_blue
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    state_t      state_reg, state_next;
    step_t       step;
    step_t       op_reg;
    logic        accept;
    logic        setup_busy;
    logic        color_mode;
    logic [8:0]  area;
    logic [23:0] pix;
    logic        rd_en;
    logic        upd;
    logic        load_out;
    logic [2:0]  lane_done;
    logic [7:0]  lane_avg [3];
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_last_reg;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pix    = color_mode ? s_axis_tdata : {16'd0, s_axis_tdata[7:0]};

    bad_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .frame_start (s_axis_tuser),
        .step        (step),
        .busy        (setup_busy),
        .color_mode  (color_mode),
        .area        (area)
    );

    // One lane per colour channel.
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        bad_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .pix    (pix[8*g +: 8]),
            .step   (step),
            .op     (op_reg),
            .rd_en  (rd_en),
            .upd    (upd),
            .area   (area),
            .avg    (lane_avg[g]),
            .done   (lane_done[g])
        );
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && step.active && step.seg_end)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = op_reg.last_row ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE:
            begin
                if (lane_done[0])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        upd           = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:   s_axis_tready = !setup_busy;
            ST_READ:   rd_en         = 1'b1;
            ST_UPDATE: upd           = 1'b1;
            ST_DIVIDE: load_out      = 1'b0;
            ST_EMIT:   load_out      = !out_valid_reg || m_axis_tready;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pixel step held for the line store and divide phases; merged result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= step;
        end
        if (load_out)
        begin
            out_data_reg <= {lane_avg[2], lane_avg[1], lane_avg[0]};
            out_last_reg <= op_reg.last_blk;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // The lanes start together and must finish together.
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
        else $error("channel lanes out of step");

    // A new result beat appears only out of the emit phase.
    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && (state_reg != ST_EMIT) |=> !out_valid_reg)
        else $error("result beat without a completed block");

    // A segment end that does not finish a block returns straight to idle.
    a_update_no_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && !op_reg.last_row |=> (state_reg == ST_IDLE))
        else $error("divide started for an unfinished block");

    // No beat is taken while the setup divisions run.
    a_no_take_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        setup_busy |-> !accept)
        else $error("beat taken during setup");

endmodule
